@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the packet header parser modules.
// Each macro expects a clock named aclk and an active-low reset named aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define PGPHDR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define PGPHDR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ hw/rtl/pgphdr_pkg.sv @@
package pgphdr_pkg;

    localparam int BYTE_W     = 8;
    localparam int TAG_W      = 6;
    localparam int LEN_W      = 24;
    localparam int LEFT_W     = 3;
    localparam int M_TDATA_W  = 48;
    localparam int M_TUSER_W  = 2;

    // Thresholds of the first new-format length octet.
    localparam logic [BYTE_W-1:0] LEN_TWO_OCTET_MIN = 8'd192;
    localparam logic [BYTE_W-1:0] LEN_PARTIAL_MIN   = 8'd224;
    localparam logic [BYTE_W-1:0] LEN_FIVE_OCTET    = 8'd255;

    // Old-format length type that means "indeterminate".
    localparam logic [1:0] OLD_LEN_INDETERMINATE = 2'd3;

    // Number of length octets that carry a 32-bit value.
    localparam logic [LEFT_W-1:0] FOUR_OCTETS = 3'd4;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NEWLEN,
        PH_NEWLEN2,
        PH_MULTI,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        EV_HDR,
        EV_ACCEPT,
        EV_BODY,
        EV_ERROR
    } event_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_NO_MARKER,
        ERR_INDETERMINATE,
        ERR_TOO_LONG,
        ERR_PARTIAL,
        ERR_TRUNCATED
    } err_t;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              final_byte;
    } in_word_t;

    typedef struct packed {
        event_t            event_res;
        logic [TAG_W-1:0]  packet_tag;
        logic [LEN_W-1:0]  body_length;
        logic [BYTE_W-1:0] body_data;
        logic              packet_done;
        err_t              error_code;
    } res_t;

endpackage

@@ hw/rtl/pgphdr_in_stage.sv @@
module pgphdr_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  pgphdr_pkg::in_word_t s_word,
    input  logic                take,
    output logic                word_valid,
    output pgphdr_pkg::in_word_t word
);
    import pgphdr_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    // A held word leaves in the same cycle that a new one may enter.
    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            word_reg <= s_word;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

@@ hw/rtl/pgphdr_core.sv @@
`include "assert_macros.svh"

module pgphdr_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  pgphdr_pkg::in_word_t word,
    output pgphdr_pkg::res_t     res
);
    import pgphdr_pkg::*;

    phase_t            phase_reg,     phase_next;
    logic [TAG_W-1:0]  tag_reg,       tag_next;
    logic [LEFT_W-1:0] left_reg,      left_next;
    logic [LEN_W-1:0]  accum_reg,     accum_next;
    logic [LEN_W-1:0]  body_left_reg, body_left_next;
    err_t              err_reg,       err_next;

    logic [BYTE_W-1:0] b;
    logic              fin;
    logic              len_ready;
    logic [LEN_W-1:0]  len_val;
    logic              fail;
    err_t              fail_code;
    logic [LEN_W-1:0]  shifted;
    logic [LEFT_W-1:0] left_dec;

    assign b        = word.in_byte;
    assign fin      = word.final_byte;
    assign shifted  = {accum_reg[LEN_W-BYTE_W-1:0], b};
    assign left_dec = left_reg - LEFT_W'(1);

    always_comb begin
        phase_next     = phase_reg;
        tag_next       = tag_reg;
        left_next      = left_reg;
        accum_next     = accum_reg;
        body_left_next = body_left_reg;
        err_next       = err_reg;
        len_ready      = 1'b0;
        len_val        = '0;
        fail           = 1'b0;
        fail_code      = ERR_NONE;

        if (err_reg == ERR_NONE) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (!b[7]) begin
                        fail      = 1'b1;
                        fail_code = ERR_NO_MARKER;
                    end else if (fin) begin
                        fail      = 1'b1;
                        fail_code = ERR_TRUNCATED;
                    end else if (!b[6]) begin
                        tag_next = TAG_W'(b[5:2]);
                        if (b[1:0] == OLD_LEN_INDETERMINATE) begin
                            fail      = 1'b1;
                            fail_code = ERR_INDETERMINATE;
                        end else begin
                            left_next  = LEFT_W'(1) << b[1:0];
                            accum_next = '0;
                            phase_next = PH_MULTI;
                        end
                    end else begin
                        tag_next   = b[5:0];
                        phase_next = PH_NEWLEN;
                    end
                end
                PH_NEWLEN: begin
                    if (b < LEN_TWO_OCTET_MIN) begin
                        len_ready = 1'b1;
                        len_val   = LEN_W'(b);
                    end else if (b < LEN_PARTIAL_MIN) begin
                        if (fin) begin
                            fail      = 1'b1;
                            fail_code = ERR_TRUNCATED;
                        end else begin
                            accum_next = LEN_W'({b[4:0], 8'h00});
                            phase_next = PH_NEWLEN2;
                        end
                    end else if (b == LEN_FIVE_OCTET) begin
                        if (fin) begin
                            fail      = 1'b1;
                            fail_code = ERR_TRUNCATED;
                        end else begin
                            accum_next = '0;
                            left_next  = FOUR_OCTETS;
                            phase_next = PH_MULTI;
                        end
                    end else begin
                        fail      = 1'b1;
                        fail_code = ERR_PARTIAL;
                    end
                end
                PH_NEWLEN2: begin
                    len_ready = 1'b1;
                    len_val   = accum_reg + LEN_W'(b) + LEN_W'(LEN_TWO_OCTET_MIN);
                end
                PH_MULTI: begin
                    if (left_reg == FOUR_OCTETS && b != '0) begin
                        fail      = 1'b1;
                        fail_code = ERR_TOO_LONG;
                    end else begin
                        accum_next = shifted;
                        left_next  = left_dec;
                        if (left_dec == '0) begin
                            len_ready = 1'b1;
                            len_val   = shifted;
                        end else if (fin) begin
                            fail      = 1'b1;
                            fail_code = ERR_TRUNCATED;
                        end
                    end
                end
                PH_BODY: begin
                    if (body_left_reg <= LEN_W'(1)) begin
                        body_left_next = '0;
                        phase_next     = PH_HEADER;
                    end else if (fin) begin
                        fail      = 1'b1;
                        fail_code = ERR_TRUNCATED;
                    end else begin
                        body_left_next = body_left_reg - LEN_W'(1);
                    end
                end
                default: begin
                    phase_next = PH_HEADER;
                end
            endcase

            // The length field is complete: accept the header.
            if (len_ready) begin
                accum_next = len_val;
                if (len_val == '0) begin
                    phase_next = PH_HEADER;
                end else if (fin) begin
                    fail      = 1'b1;
                    fail_code = ERR_TRUNCATED;
                end else begin
                    body_left_next = len_val;
                    phase_next     = PH_BODY;
                end
            end

            if (fail) begin
                err_next = fail_code;
            end
        end
    end

    // Result word for the byte being decoded.
    always_comb begin
        res = '{EV_HDR, '0, '0, '0, 1'b0, ERR_NONE};
        if (err_reg != ERR_NONE) begin
            res = '{EV_ERROR, '0, '0, '0, 1'b0, err_reg};
        end else if (fail) begin
            res = '{EV_ERROR, '0, '0, '0, 1'b0, fail_code};
        end else if (len_ready) begin
            if (len_val == '0) begin
                res = '{EV_ACCEPT, tag_reg, '0, '0, 1'b1, ERR_NONE};
            end else begin
                res = '{EV_ACCEPT, tag_reg, len_val, '0, 1'b0, ERR_NONE};
            end
        end else if (phase_reg == PH_BODY) begin
            res = '{EV_BODY, tag_reg, accum_reg, b, body_left_reg <= LEN_W'(1), ERR_NONE};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            tag_reg       <= '0;
            left_reg      <= '0;
            accum_reg     <= '0;
            body_left_reg <= '0;
            err_reg       <= ERR_NONE;
        end else if (fire) begin
            phase_reg     <= phase_next;
            tag_reg       <= tag_next;
            left_reg      <= left_next;
            accum_reg     <= accum_next;
            body_left_reg <= body_left_next;
            err_reg       <= err_next;
        end
    end

    `PGPHDR_ASSERT_ALWAYS(a_error_sticky, (aresetn && err_reg != ERR_NONE) |=> (!aresetn || err_reg == $past(err_reg)), "sticky error changed without reset")
    `PGPHDR_ASSERT(a_body_nonempty, (phase_reg == PH_BODY) |-> (body_left_reg != '0), "body phase with no bytes left")

endmodule

@@ hw/rtl/pgphdr_out_stage.sv @@
`include "assert_macros.svh"

module pgphdr_out_stage (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 load,
    input  pgphdr_pkg::res_t                     res,
    output logic                                 can_load,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pgphdr_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [pgphdr_pkg::M_TUSER_W-1:0]     m_tuser,
    output logic                                 m_tlast
);
    import pgphdr_pkg::*;

    localparam int PAD_W = M_TDATA_W - TAG_W - LEN_W - BYTE_W - 3;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign can_load   = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.event_res;
    assign m_tlast  = res_reg.packet_done;
    assign m_tdata  = {{PAD_W{1'b0}}, res_reg.error_code, res_reg.body_data,
                       res_reg.body_length, res_reg.packet_tag};

    `PGPHDR_ASSERT(a_error_code_matches, m_tvalid |-> ((res_reg.event_res == EV_ERROR) == (res_reg.error_code != ERR_NONE)), "error code disagrees with event")

endmodule

@@ hw/rtl/openpgp_packet_header_parser.sv @@
// OpenPGP packet header parser. Bytes of a packet stream enter one word per clock on the
// s_ channel, with s_tlast marking the last byte of the buffer; every accepted byte gives
// exactly one result word on the m_ channel. Headers of both the old format (4-bit tag,
// 1, 2 or 4 length octets) and the new format (6-bit tag, 1, 2 or 5 length octets) are
// decoded, then the body bytes pass through and the byte after the body starts a new
// header. The event in m_tuser tells a header byte, an accepted header, a body byte or an
// error; m_tlast flags the byte that completes a packet. The first error (missing marker
// bit, indeterminate or partial length, length above 24 bits, or a buffer that ends
// inside a packet) is held until reset, and every later byte answers with it. The block
// sustains one byte per clock while m_tready is high: an input register and a result
// register enclose one pass of decode logic that also updates the parser state, so each
// byte is held in the input register, decoded, and presented on m_tvalid from the result
// register. Both registers hand off in the same cycle that they refill, so stalls on the
// m_ side hold the stream without losing or repeating a word.
module openpgp_packet_header_parser (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] in_byte
    input  logic                             s_tlast,   // final_byte
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [5:0] packet_tag, [29:6] body_length, [37:30] body_data, [40:38] error_code,
    // [47:41] zero
    output logic [pgphdr_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [pgphdr_pkg::M_TUSER_W-1:0] m_tuser,   // [1:0] event_res
    output logic                             m_tlast    // packet_done
);
    import pgphdr_pkg::*;

    in_word_t s_word;
    in_word_t word;
    logic     word_valid;
    logic     can_load;
    logic     fire;
    res_t     res;

    assign s_word = '{in_byte: s_tdata, final_byte: s_tlast};

    // A byte is decoded when it sits in the input register and the result
    // register is free or being emptied in the same cycle.
    assign fire = word_valid && can_load;

    pgphdr_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_word     (s_word),
        .take       (fire),
        .word_valid (word_valid),
        .word       (word)
    );

    pgphdr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .word    (word),
        .res     (res)
    );

    pgphdr_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import pgphdr_pkg::*;

    // Ways to encode a body length in a header.
    typedef enum {
        ENC_OLD1,
        ENC_OLD2,
        ENC_OLD4,
        ENC_NEW1,
        ENC_NEW2,
        ENC_NEW5
    } len_enc_t;

    // Ways to break the stream at the end of the run.
    typedef enum {
        BRK_NO_MARKER,
        BRK_INDETERMINATE,
        BRK_PARTIAL,
        BRK_TOO_LONG,
        BRK_HDR_FIN,
        BRK_LEN_FIN,
        BRK_BODY_FIN
    } break_t;

    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          DRAIN_CYCLES   = 10;
    localparam int unsigned NEW2_MAX_LEN   = 8383;
    localparam int unsigned OLD1_MAX_LEN   = 255;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'd0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;

    // Parser state as the predictor sees it.
    phase_t                pstate    = PH_HEADER;
    logic [TAG_W-1:0]      cur_tag   = '0;
    logic [LEFT_W-1:0]     len_left  = '0;
    logic [31:0]           len_acc   = '0;
    logic [LEN_W-1:0]      body_rem  = '0;
    err_t                  held_err  = ERR_NONE;

    res_t                  expected_words[$];
    int                    mismatches    = 0;
    int                    words_checked = 0;
    int                    bytes_sent    = 0;
    int                    cycles        = 0;
    int                    hold_cycles   = 0;
    int                    send_idle_pct = 29;
    int                    recv_idle_pct = 48;
    string                 closing_case  = "none";

    openpgp_packet_header_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side readiness. A requested hold-off overrides the random stalls.
    always @(posedge aclk) begin
        if (hold_cycles != 0) begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Works out the result word for one accepted byte and advances the predicted state.
    task automatic parse_byte(input logic [7:0] b, input logic fin);
        event_t           ev;
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] blen;
        logic [7:0]       data;
        logic             done;
        err_t             code;
        logic             got_len;
        logic [31:0]      lenv;
        res_t             w;
        ev      = EV_HDR;
        tag     = '0;
        blen    = '0;
        data    = '0;
        done    = 1'b0;
        code    = ERR_NONE;
        got_len = 1'b0;
        lenv    = '0;
        if (held_err != ERR_NONE) begin
            code = held_err;
        end else begin
            case (pstate)
                PH_HEADER: begin
                    // The marker bit is checked ahead of the final flag.
                    if (!b[7]) begin
                        code = ERR_NO_MARKER;
                    end else if (fin) begin
                        code = ERR_TRUNCATED;
                    end else if (!b[6]) begin
                        cur_tag = {2'b00, b[5:2]};
                        if (b[1:0] == OLD_LEN_INDETERMINATE) begin
                            code = ERR_INDETERMINATE;
                        end else begin
                            len_left = 3'd1 << b[1:0];
                            len_acc  = '0;
                            pstate   = PH_MULTI;
                        end
                    end else begin
                        cur_tag = b[5:0];
                        pstate  = PH_NEWLEN;
                    end
                end
                PH_NEWLEN: begin
                    if (b < LEN_TWO_OCTET_MIN) begin
                        got_len = 1'b1;
                        lenv    = {24'd0, b};
                    end else if (b < LEN_PARTIAL_MIN) begin
                        if (fin) begin
                            code = ERR_TRUNCATED;
                        end else begin
                            len_acc = {16'd0, b - LEN_TWO_OCTET_MIN, 8'd0};
                            pstate  = PH_NEWLEN2;
                        end
                    end else if (b == LEN_FIVE_OCTET) begin
                        if (fin) begin
                            code = ERR_TRUNCATED;
                        end else begin
                            len_acc  = '0;
                            len_left = FOUR_OCTETS;
                            pstate   = PH_MULTI;
                        end
                    end else begin
                        code = ERR_PARTIAL;
                    end
                end
                PH_NEWLEN2: begin
                    got_len = 1'b1;
                    lenv    = len_acc + {24'd0, b} + 32'd192;
                end
                PH_MULTI: begin
                    // A four-octet length must keep its top octet clear.
                    if (len_left == FOUR_OCTETS && b != 8'd0) begin
                        code = ERR_TOO_LONG;
                    end else begin
                        len_acc  = {len_acc[23:0], b};
                        len_left = len_left - 3'd1;
                        if (len_left == '0) begin
                            got_len = 1'b1;
                            lenv    = len_acc;
                        end else if (fin) begin
                            code = ERR_TRUNCATED;
                        end
                    end
                end
                PH_BODY: begin
                    ev   = EV_BODY;
                    tag  = cur_tag;
                    blen = len_acc[LEN_W-1:0];
                    data = b;
                    if (body_rem <= 1) begin
                        body_rem = '0;
                        pstate   = PH_HEADER;
                        done     = 1'b1;
                    end else if (fin) begin
                        code = ERR_TRUNCATED;
                    end else begin
                        body_rem = body_rem - 24'd1;
                    end
                end
                default: pstate = PH_HEADER;
            endcase
            // A complete length accepts the header; a zero length also ends the packet.
            if (got_len) begin
                len_acc = lenv;
                if (lenv == 0) begin
                    pstate = PH_HEADER;
                    ev     = EV_ACCEPT;
                    tag    = cur_tag;
                    done   = 1'b1;
                end else if (fin) begin
                    code = ERR_TRUNCATED;
                end else begin
                    body_rem = lenv[LEN_W-1:0];
                    pstate   = PH_BODY;
                    ev       = EV_ACCEPT;
                    tag      = cur_tag;
                    blen     = lenv[LEN_W-1:0];
                end
            end
        end
        // Errors stick, and an error word carries nothing but its code.
        if (code != ERR_NONE) begin
            held_err = code;
            ev       = EV_ERROR;
            tag      = '0;
            blen     = '0;
            data     = '0;
            done     = 1'b0;
        end
        w.event_res   = ev;
        w.packet_tag  = tag;
        w.body_length = blen;
        w.body_data   = data;
        w.packet_done = done;
        w.error_code  = code;
        expected_words.push_back(w);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Result words are checked before the byte accepted at the same edge is predicted;
    // that byte's own result cannot leave the block before a later edge.
    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word with none expected, actual tuser %0h tdata %0h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = expected_words.pop_front();
                    compare_field("event_res", want.event_res, m_tuser);
                    compare_field("packet_tag", want.packet_tag, m_tdata[5:0]);
                    compare_field("body_length", want.body_length, m_tdata[29:6]);
                    compare_field("body_data", want.body_data, m_tdata[37:30]);
                    compare_field("error_code", want.error_code, m_tdata[40:38]);
                    compare_field("tdata padding", 32'd0, m_tdata[47:41]);
                    compare_field("packet_done", want.packet_done, m_tlast);
                    words_checked++;
                end
            end
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tlast);
        end
    end

    // Offers one word, with random idle cycles ahead of it, and returns once it is taken.
    // The valid stays high on return so back-to-back words need no extra edge.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    // Stops offering words and waits until every predicted result has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_words.size() != 0)
            @(posedge aclk);
    endtask

    // Sends one well-formed packet. The final flag, if asked for, goes on the packet's
    // last byte: the last body byte, or the last length octet of an empty packet.
    task automatic send_packet(input len_enc_t enc, input logic [5:0] tag,
                               input int unsigned blen, input logic fin_end);
        logic [31:0] lv;
        int          n;
        lv = blen;
        case (enc)
            ENC_OLD1: begin
                send_byte({2'b10, tag[3:0], 2'd0}, 1'b0);
                n = 1;
            end
            ENC_OLD2: begin
                send_byte({2'b10, tag[3:0], 2'd1}, 1'b0);
                n = 2;
            end
            ENC_OLD4: begin
                send_byte({2'b10, tag[3:0], 2'd2}, 1'b0);
                n = 4;
            end
            ENC_NEW1: begin
                send_byte({2'b11, tag}, 1'b0);
                n = 1;
            end
            ENC_NEW2: begin
                send_byte({2'b11, tag}, 1'b0);
                lv = blen - 32'd192;
                send_byte(LEN_TWO_OCTET_MIN + lv[15:8], 1'b0);
                n = 1;
            end
            default: begin
                send_byte({2'b11, tag}, 1'b0);
                send_byte(LEN_FIVE_OCTET, 1'b0);
                n = 4;
            end
        endcase
        for (int i = n - 1; i >= 0; i--)
            send_byte(lv[8*i +: 8], fin_end && i == 0 && blen == 0);
        for (int unsigned k = 0; k < blen; k++)
            send_byte(8'($urandom), fin_end && k == blen - 1);
    endtask

    // Mostly short packets so headers come often; now and then a few dozen bytes.
    task automatic send_random_packet();
        int unsigned blen;
        int unsigned r;
        len_enc_t    enc;
        logic        fits;
        r = $urandom_range(99);
        if (r < 55)
            blen = $urandom_range(3);
        else if (r < 95)
            blen = $urandom_range(16, 4);
        else
            blen = $urandom_range(40, 20);
        fits = 1'b0;
        while (!fits) begin
            enc  = len_enc_t'($urandom_range(5));
            fits = (enc == ENC_NEW1 && blen < 192) ||
                   (enc == ENC_NEW2 && blen >= 192 && blen <= NEW2_MAX_LEN) ||
                   (enc == ENC_OLD1 && blen <= OLD1_MAX_LEN) ||
                   enc == ENC_OLD2 || enc == ENC_OLD4 || enc == ENC_NEW5;
        end
        send_packet(enc, 6'($urandom_range(63)), blen, $urandom_range(3) == 0);
    endtask

    // Short packets in every encoding but the two-octet new one, extreme tags, extreme body
    // bytes, and the final flag on an empty packet's length octet and on a last body byte.
    task automatic test_directed_headers();
        send_packet(ENC_NEW1, 6'd63, 0, 1'b1);
        send_byte(8'hBC, 1'b0);              // old format, tag 15, one length octet
        send_byte(8'd2, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_packet(ENC_OLD2, 6'd0, 0, 1'b0);
        send_packet(ENC_OLD4, 6'd5, 0, 1'b0);
        send_packet(ENC_NEW5, 6'd0, 0, 1'b1);
        send_packet(ENC_NEW1, 6'd42, 1, 1'b0);
    endtask

    // The smallest two-octet length, with the final flag on its last body byte.
    task automatic test_long_bodies();
        send_packet(ENC_NEW2, 6'($urandom_range(63)), 192, 1'b1);
    endtask

    // Random well-formed packets. Broken input would end all useful checking, since
    // errors stick until reset, so it is saved for the close of the run.
    task automatic test_random_stream(input int n);
        int target;
        target = bytes_sent + n;
        while (bytes_sent < target)
            send_random_packet();
    endtask

    // The receiver stops for a long stretch while words keep coming, so the block fills
    // and holds its input; then the sender waits until the block has drained.
    task automatic test_backpressure();
        hold_cycles <= 80;
        for (int p = 0; p < 6; p++)
            send_packet(ENC_NEW1, 6'($urandom_range(63)), $urandom_range(8, 4), 1'b0);
        wait_for_results();
    endtask

    // One error is all a run can show, so the kind is picked at random; every byte after
    // it must answer with the same code.
    task automatic test_sticky_error();
        break_t      pick;
        logic [5:0]  tag;
        pick = break_t'($urandom_range(6));
        tag  = 6'($urandom_range(63));
        case (pick)
            BRK_NO_MARKER: begin
                // Final flag set too: the missing marker must win.
                closing_case = "missing marker bit";
                send_byte({1'b0, 7'($urandom)}, 1'b1);
            end
            BRK_INDETERMINATE: begin
                closing_case = "indeterminate old length";
                send_byte({2'b10, tag[3:0], OLD_LEN_INDETERMINATE}, 1'b0);
            end
            BRK_PARTIAL: begin
                closing_case = "partial new length";
                send_byte({2'b11, tag}, 1'b0);
                send_byte(8'($urandom_range(254, 224)), 1'b0);
            end
            BRK_TOO_LONG: begin
                closing_case = "four-octet length above 24 bits";
                if ($urandom_range(1) == 0) begin
                    send_byte({2'b10, tag[3:0], 2'd2}, 1'b0);
                end else begin
                    send_byte({2'b11, tag}, 1'b0);
                    send_byte(LEN_FIVE_OCTET, 1'b0);
                end
                send_byte(8'($urandom_range(255, 1)), 1'b0);
            end
            BRK_HDR_FIN: begin
                closing_case = "final flag on a header byte";
                send_byte({1'b1, 7'($urandom)}, 1'b1);
            end
            BRK_LEN_FIN: begin
                closing_case = "final flag on a nonzero length";
                send_byte({2'b11, tag}, 1'b0);
                send_byte(8'($urandom_range(191, 1)), 1'b1);
            end
            default: begin
                closing_case = "final flag inside a body";
                send_byte({2'b11, tag}, 1'b0);
                send_byte(8'd6, 1'b0);
                send_byte(8'($urandom), 1'b0);
                send_byte(8'($urandom), 1'b1);
            end
        endcase
        for (int i = 0; i < 12; i++)
            send_byte(8'($urandom), 1'($urandom_range(1)));
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sender idles less than the receiver.
        test_directed_headers();
        test_long_bodies();
        test_random_stream(50);

        // Receiver idles less than the sender.
        send_idle_pct = 48;
        recv_idle_pct <= 29;
        test_random_stream(50);

        // Neither side idles apart from the forced hold-off.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        test_backpressure();
        test_random_stream(50);
        test_sticky_error();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes and checked %0d result words: both header formats,",
                 bytes_sent, words_checked);
        $display("every length encoding, long stalls, and a closing %s error.",
                 closing_case);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
